>>> rtl/bce_pkg.sv
package bce_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxClique   = 8;
	localparam int VtxW   = $clog2(MaxVertices);
	localparam int CntW   = $clog2(MaxVertices + 1);
	localparam int PosW   = $clog2(MaxClique);
	localparam int LvlW   = $clog2(MaxClique + 1);

	typedef enum logic [1:0] {
		CFG_START_VERTEX = 2'd0,
		CFG_MAX_SIZE     = 2'd1,
		CFG_VERTEX_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_NEXT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_DONE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_LOAD,
		S_EMIT,
		S_END
	} state_t;
endpackage

>>> rtl/bce_in_if.sv
interface bce_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [5:0]  row;
	logic [63:0] row_bits;
	modport source (output valid, op, row, row_bits, input ready);
	modport sink   (input valid, op, row, row_bits, output ready);
endinterface

>>> rtl/bce_out_if.sv
interface bce_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] vertex;
	logic [2:0] position;
	logic       last;
	logic       found;
	modport source (output valid, vertex, position, last, found, input ready);
	modport sink   (input valid, vertex, position, last, found, output ready);
endinterface

>>> rtl/bce_cfg_if.sv
interface bce_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bounded_clique_enumerator.sv
// Clique enumerator over a graph held in a 64x64 adjacency RAM. A load word
// (op 0) writes one row and restarts the search, as does any register
// write; register writes are taken only while the block is idle and no input
// word is offered. A next word (op 1) scans candidate vertices one per
// cycle, pausing for a RAM row read on each vertex that joins below the size
// limit. The cursor only moves forward within a request, so a request scans
// each vertex below vertex_count (clamped to 64) at most once and reads at
// most one row fewer than max_size (clamped to 1 to 8), then sends the clique
// one vertex per word. The input waits until the last word is taken, so the
// block takes no new request while one is in flight. Rows must be loaded
// before any search reads them.
module bounded_clique_enumerator (
	input  logic clk,
	input  logic arst_n,
	bce_in_if.sink    in_ch,
	bce_out_if.source out_ch,
	bce_cfg_if.sink   cfg
);
	import bce_pkg::*;

	logic [VtxW-1:0] start_q;
	logic [3:0]      max_size_q;
	logic [CntW-1:0] vcount_q;
	phase_t          phase_q;
	state_t          state_q, state_d;
	logic [LvlW-1:0] level_q;
	logic [PosW-1:0] k_q;
	logic [CntW-1:0] cursor_q;
	logic [MaxVertices-1:0] mask_q;
	logic [VtxW-1:0] stk_q [MaxClique];
	logic [MaxVertices-1:0] mstk_q [MaxClique];
	logic [MaxVertices-1:0] adj_mem [MaxVertices];
	logic [MaxVertices-1:0] rd_q;

	logic [LvlW-1:0] lim;
	logic [CntW-1:0] n_lim;
	logic [PosW-1:0] sidx;
	logic            in_acc, out_acc, cfg_acc, cand_ok, cand_hit, emit_last;

	// clamp configuration
	always_comb begin
		if (max_size_q == 4'd0)
			lim = LvlW'(1);
		else if (max_size_q > 4'(MaxClique))
			lim = LvlW'(MaxClique);
		else
			lim = LvlW'(max_size_q);
		n_lim = (vcount_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vcount_q;
	end

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_acc  = out_ch.valid && out_ch.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign cand_ok  = cursor_q < n_lim;
	assign cand_hit = cand_ok && mask_q[cursor_q[VtxW-1:0]];
	assign sidx     = (state_q == S_EMIT) ? k_q : PosW'(level_q - LvlW'(1));
	assign emit_last = (LvlW'(k_q) + LvlW'(1)) == level_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_ch.op == OP_NEXT) begin
					if (phase_q == PH_DONE || (phase_q == PH_RUN && level_q == '0))
						state_d = S_END;
					else
						state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (cand_hit)
					state_d = (level_q + LvlW'(1) >= lim) ? S_EMIT : S_LOAD;
				else if (!cand_ok)
					state_d = (level_q == '0) ? S_END : S_EMIT;
			end
			S_LOAD: state_d = S_SCAN;
			S_EMIT: if (out_acc && emit_last) state_d = S_IDLE;
			S_END:  if (out_acc) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready     = (state_q == S_IDLE);
		cfg.ready       = (state_q == S_IDLE) && !in_ch.valid;
		out_ch.valid    = (state_q == S_EMIT) || (state_q == S_END);
		out_ch.vertex   = (state_q == S_EMIT) ? stk_q[sidx] : '0;
		out_ch.position = (state_q == S_EMIT) ? k_q : '0;
		out_ch.last     = (state_q == S_EMIT) ? emit_last : 1'b1;
		out_ch.found    = (state_q == S_EMIT);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_IDLE;
			level_q    <= '0;
			k_q        <= '0;
			start_q    <= '0;
			max_size_q <= 4'd3;
			vcount_q   <= CntW'(MaxVertices);
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg.index)
					CFG_START_VERTEX: start_q    <= cfg.data[VtxW-1:0];
					CFG_MAX_SIZE:     max_size_q <= cfg.data[3:0];
					CFG_VERTEX_COUNT: vcount_q   <= cfg.data[CntW-1:0];
					default: ;
				endcase
				if (cfg.index inside {CFG_START_VERTEX, CFG_MAX_SIZE, CFG_VERTEX_COUNT}) begin
					phase_q <= PH_IDLE;
					level_q <= '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (in_acc) begin
						if (in_ch.op == OP_LOAD) begin
							phase_q <= PH_IDLE;
							level_q <= '0;
						end else if (phase_q == PH_IDLE) begin
							level_q <= '0;
						end else if (phase_q == PH_RUN && level_q != '0) begin
							level_q <= level_q - LvlW'(1);
						end
					end
				end
				S_SCAN: if (cand_hit) level_q <= level_q + LvlW'(1);
				S_EMIT: begin
					phase_q <= PH_RUN;
					if (out_acc) k_q <= k_q + PosW'(1);
				end
				S_END: phase_q <= PH_DONE;
				default: ;
			endcase
		end
	end

	// search datapath: cursor, candidate mask, clique stack
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (phase_q == PH_IDLE) begin
					cursor_q <= CntW'(start_q);
					mask_q   <= '1;
				end else begin
					cursor_q <= CntW'(stk_q[sidx]) + CntW'(1);
					mask_q   <= mstk_q[sidx];
				end
			end
			S_SCAN: begin
				cursor_q <= cursor_q + CntW'(1);
				if (cand_hit) begin
					stk_q[level_q[PosW-1:0]]  <= cursor_q[VtxW-1:0];
					mstk_q[level_q[PosW-1:0]] <= mask_q;
				end
			end
			S_LOAD: mask_q <= mask_q & rd_q;
			default: ;
		endcase
	end

	// adjacency RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && in_ch.op == OP_LOAD)
			adj_mem[in_ch.row] <= in_ch.row_bits;
		rd_q <= adj_mem[cursor_q[VtxW-1:0]];
	end
endmodule

>>> verif/bce_tb_if.sv
// Testbench-side copies of the channel interfaces are not needed: the RTL
// interfaces are reused directly. This file holds shared testbench types.
package bce_tb_pkg;
	import bce_pkg::*;

	// one word leaving the block
	typedef struct packed {
		logic [5:0] vertex;
		logic [2:0] position;
		logic       last;
		logic       found;
	} clique_word_t;

	// one stimulus row: op, row index, row bits, and an optional typed-in answer
	typedef struct {
		op_t         op;
		logic [5:0]  row;
		logic [63:0] row_bits;
		bit          has_known;
		clique_word_t known;
	} stim_row_t;
endpackage

>>> verif/testbench.sv
module testbench;
	import bce_pkg::*;
	import bce_tb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchdogLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bce_in_if  in_ch();
	bce_out_if out_ch();
	bce_cfg_if cfg();

	bounded_clique_enumerator uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [63:0] graph_rows [MaxVertices];
	logic [6:0]  members [MaxClique];
	int          depth;
	phase_t      phase;
	logic [5:0]  first_vertex;
	logic [3:0]  size_limit;
	logic [6:0]  vertex_limit;

	clique_word_t pending_words[$];
	int errors = 0;
	int words_checked = 0;
	int cliques_seen = 0;
	int ends_seen = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	function automatic bit can_join(int c);
		for (int p = 0; p < depth; p++) begin
			if (graph_rows[members[p]][c] == 1'b0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic push_clique();
		clique_word_t w;
		phase = PH_RUN;
		for (int k = 0; k < depth; k++) begin
			w.vertex = members[k][5:0];
			w.position = k[2:0];
			w.last = (k + 1 == depth);
			w.found = 1'b1;
			pending_words.push_back(w);
		end
		cliques_seen++;
	endtask

	task automatic push_end();
		clique_word_t w;
		phase = PH_DONE;
		w = '{vertex: 6'd0, position: 3'd0, last: 1'b1, found: 1'b0};
		pending_words.push_back(w);
		ends_seen++;
	endtask

	task automatic restart_search();
		phase = PH_IDLE;
		depth = 0;
	endtask

	// work out the words that one accepted request causes
	task automatic predict_next_clique();
		int lim;
		int n;
		int cursor;
		int c;
		bit hit;
		lim = size_limit;
		n = vertex_limit;
		if (lim == 0) lim = 1;
		if (lim > MaxClique) lim = MaxClique;
		if (n > MaxVertices) n = MaxVertices;
		if (phase == PH_DONE) begin
			push_end();
			return;
		end
		if (phase == PH_IDLE) begin
			depth = 0;
			cursor = first_vertex;
		end else begin
			if (depth == 0) begin
				push_end();
				return;
			end
			depth--;
			cursor = members[depth] + 1;
		end
		forever begin
			hit = 1'b0;
			for (c = cursor; c < n; c++) begin
				if (can_join(c)) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit && depth < lim) begin
				members[depth] = c[6:0];
				depth++;
				if (depth >= lim) begin
					push_clique();
					return;
				end
				cursor = c + 1;
				continue;
			end
			if (depth == 0)
				push_end();
			else
				push_clique();
			return;
		end
	endtask

	// drive idle values from time zero
	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_LOAD;
		in_ch.row = '0;
		in_ch.row_bits = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_START_VERTEX;
		cfg.data = '0;
		out_ch.ready = 1'b0;
		for (int i = 0; i < MaxVertices; i++)
			graph_rows[i] = '0;
		for (int i = 0; i < MaxClique; i++)
			members[i] = '0;
		depth = 0;
		phase = PH_IDLE;
		first_vertex = 6'd0;
		size_limit = 4'd3;
		vertex_limit = 7'd64;
	end

	// receiver: random stalls, one long hold-off, quiet stretch when no_idle
	always @(negedge clk) begin
		if (!arst_n || hold_off)
			out_ch.ready <= 1'b0;
		else if (no_idle)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(99) >= 12);
	end

	// check each accepted word against the oldest expectation
	always @(posedge clk) begin
		clique_word_t w;
		clique_word_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			w = '{vertex: out_ch.vertex, position: out_ch.position,
				last: out_ch.last, found: out_ch.found};
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, actual %p", $time, w);
				errors++;
			end else begin
				e = pending_words.pop_front();
				words_checked++;
				if (w !== e) begin
					$display("%0t: mismatch, expected %p actual %p", $time, e, w);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("%0t: timeout, %0d words outstanding", $time,
				pending_words.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// drop valid for each idle cycle taken
	task automatic random_gap();
		if (!no_idle)
			while ($urandom_range(99) < 12) begin
				in_ch.valid <= 1'b0;
				@(negedge clk);
			end
	endtask

	// send one word on the input channel and predict its effect
	task automatic send_word(op_t op, logic [5:0] r, logic [63:0] bits);
		random_gap();
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.row <= r;
		in_ch.row_bits <= bits;
		do @(posedge clk); while (!in_ch.ready);
		if (op == OP_LOAD) begin
			graph_rows[r] = bits;
			restart_search();
		end else begin
			predict_next_clique();
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(cfg_idx_t idx, logic [6:0] value);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			CFG_START_VERTEX: first_vertex = value[5:0];
			CFG_MAX_SIZE:     size_limit = value[3:0];
			default:          vertex_limit = value;
		endcase
		restart_search();
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// random graph: edge density from the caller, rows below the given count loaded
	task automatic load_graph(int density, int rows);
		logic [63:0] bits;
		for (int r = 0; r < rows; r++) begin
			for (int k = 0; k < 64; k++)
				bits[k] = ($urandom_range(99) < density);
			send_word(OP_LOAD, r[5:0], bits);
		end
	endtask

	task automatic request_cliques(int count);
		for (int i = 0; i < count; i++)
			send_word(OP_NEXT, 6'($urandom), 64'({$urandom, $urandom}));
	endtask

	stim_row_t directed [$];

	initial begin
		stim_row_t s;
		clique_word_t end_word;
		int count_sel;
		end_word = '{vertex: 6'd0, position: 3'd0, last: 1'b1, found: 1'b0};
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero rows for every vertex the directed searches read
		for (int r = 0; r < 8; r++)
			send_word(OP_LOAD, r[5:0], 64'd0);
		send_word(OP_LOAD, 6'd63, 64'd0);
		write_reg(CFG_START_VERTEX, 7'd63);
		// start at vertex 63 with 64 vertices: single-member clique, then the end
		directed.push_back('{OP_NEXT, 6'd0, 64'd0, 1'b1,
			'{vertex: 6'd63, position: 3'd0, last: 1'b1, found: 1'b1}});
		directed.push_back('{OP_NEXT, 6'd63, '1, 1'b1, end_word});
		directed.push_back('{OP_NEXT, 6'd0, 64'd0, 1'b1, end_word});
		// full row on vertex 62 and only bits 0 and 63 set on row 63
		directed.push_back('{OP_LOAD, 6'd62, '1, 1'b0, end_word});
		directed.push_back('{OP_LOAD, 6'd63, 64'h8000_0000_0000_0001, 1'b0, end_word});
		directed.push_back('{OP_NEXT, 6'd0, 64'd0, 1'b0, end_word});
		directed.push_back('{OP_NEXT, 6'd0, 64'd0, 1'b0, end_word});
		foreach (directed[i]) begin
			clique_word_t seen;
			s = directed[i];
			if (s.has_known) begin
				send_word(s.op, s.row, s.row_bits);
				seen = pending_words[pending_words.size() - 1];
				if (seen !== s.known) begin
					$display("%0t: mismatch, expected %p actual %p", $time, s.known, seen);
					errors++;
				end
			end else
				send_word(s.op, s.row, s.row_bits);
		end
		// start vertex beyond vertex count, size extremes, zero-count graph
		write_reg(CFG_VERTEX_COUNT, 7'd10);
		request_cliques(2);
		write_reg(CFG_VERTEX_COUNT, 7'd0);
		request_cliques(2);
		write_reg(CFG_VERTEX_COUNT, 7'd127);
		write_reg(CFG_START_VERTEX, 7'd0);
		write_reg(CFG_MAX_SIZE, 7'd0);
		request_cliques(3);
		write_reg(CFG_MAX_SIZE, 7'd15);
		request_cliques(3);

		// random: dense small graph, size 8, with a quiet stretch
		write_reg(CFG_VERTEX_COUNT, 7'd12);
		write_reg(CFG_MAX_SIZE, 7'd8);
		load_graph(70, 12);
		no_idle = 1'b1;
		request_cliques(20);
		no_idle = 1'b0;

		// long receiver hold-off while requests keep coming
		wait_drained();
		fork
			begin
				hold_off = 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			request_cliques(25);
		join

		// random settings: varied start, size and count
		count_sel = $urandom_range(8, 20);
		write_reg(CFG_START_VERTEX, 7'($urandom_range(5)));
		write_reg(CFG_MAX_SIZE, 7'($urandom_range(2, 4)));
		write_reg(CFG_VERTEX_COUNT, 7'(count_sel));
		load_graph(50, count_sel);
		request_cliques(25);
		write_reg(CFG_MAX_SIZE, 7'd1);
		write_reg(CFG_VERTEX_COUNT, 7'd64);
		write_reg(CFG_START_VERTEX, 7'd60);
		request_cliques(6);
		wait_drained();

		$display("Checked %0d words: %0d cliques and %0d end words predicted,",
			words_checked, cliques_seen, ends_seen);
		$display("across sizes 1 to 8, vertex counts 0 to 64 and a long output stall.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
